[rtl/core/assert_macros.svh]
// assertion macros used by the blur control module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) else $error(msg);

`endif

[rtl/core/gblur_pkg.sv]
// shared types, constants and kernel arithmetic of the 3x3 blur
package gblur_pkg;

  // field widths and register reset values
  localparam int unsigned FW_W      = 11;
  localparam int unsigned FH_W      = 13;
  localparam int unsigned FW_RESET  = 640;
  localparam int unsigned FH_RESET  = 480;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // request kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // per-request flags decided at intake
  typedef struct packed {
    logic produce;
    logic border;
    logic frame_end;
  } tag_t;

  // one line store entry: two rows back, one row back
  typedef struct packed {
    rgb_t far_px;
    rgb_t near_px;
  } line_t;

  // weighted 3x3 sum of one channel, divided by 16
  function automatic logic [7:0] blur_chan(
    input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2,
    input logic [7:0] p3, input logic [7:0] p4, input logic [7:0] p5,
    input logic [7:0] p6, input logic [7:0] p7, input logic [7:0] p8
  );
    logic [11:0] corners;
    logic [11:0] edges;
    logic [11:0] s;
    corners = {4'b0, p0} + {4'b0, p2} + {4'b0, p6} + {4'b0, p8};
    edges   = {4'b0, p1} + {4'b0, p3} + {4'b0, p5} + {4'b0, p7};
    s       = corners + {edges[10:0], 1'b0} + {2'b0, p4, 2'b0};
    return s[11:4];
  endfunction

endpackage

[rtl/core/gblur_ctrl.sv]
// frame position tracking and per-request decisions at intake
module gblur_ctrl #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          acc_i,
  input  logic                          cmd_i,
  input  gblur_pkg::rgb_t               px_i,
  input  logic [gblur_pkg::FW_W-1:0]    frame_width_i,
  input  logic [gblur_pkg::FH_W-1:0]    frame_height_i,
  output logic                          take_o,
  output gblur_pkg::tag_t               tag_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  addr_o,
  output gblur_pkg::rgb_t               px_o
);
  import gblur_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned OYW = $clog2(MAX_HEIGHT);
  localparam int unsigned CW  = (WW > FW_W) ? WW : FW_W;
  localparam int unsigned CH  = (HW > FH_W) ? HW : FH_W;

  logic [CW-1:0]  fw_x;
  logic [CH-1:0]  fh_x;
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [WW-1:0]  w_m1;
  logic [HW-1:0]  h_m1;

  logic [AW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [AW-1:0]  ox_q, ox_d;
  logic [OYW-1:0] oy_q, oy_d;

  logic frame_in;
  logic keep;
  logic produce;
  logic last_col;
  logic ox_last;
  logic fend;
  logic border;

  // effective frame size: zero acts as one, oversize clamps to the maximum
  always_comb begin
    fw_x = CW'(frame_width_i);
    fh_x = CH'(frame_height_i);
    if (fw_x == '0) begin
      eff_w = WW'(1);
    end else if (fw_x > CW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_x);
    end
    if (fh_x == '0) begin
      eff_h = HW'(1);
    end else if (fh_x > CH'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(fh_x);
    end
    w_m1 = eff_w - WW'(1);
    h_m1 = eff_h - HW'(1);
  end

  // decisions for the request at the port
  always_comb begin
    frame_in = (row_q >= RW'(eff_h));
    keep     = ((cmd_i == CMD_DRAIN) == frame_in);
    produce  = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
    last_col = ((WW'(col_q) + WW'(1)) == eff_w);
    ox_last  = (WW'(ox_q) == w_m1);
    fend     = ox_last && (HW'(oy_q) == h_m1);
    border   = (ox_q == '0) || (oy_q == '0) || ox_last || (HW'(oy_q) >= h_m1);
  end

  assign take_o          = keep;
  assign tag_o.produce   = produce;
  assign tag_o.border    = border;
  assign tag_o.frame_end = fend;
  assign addr_o          = col_q;
  assign px_o            = (cmd_i == CMD_DRAIN) ? '0 : px_i;

  // next position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    ox_d  = ox_q;
    oy_d  = oy_q;
    if (clear_i) begin
      col_d = '0;
      row_d = '0;
      ox_d  = '0;
      oy_d  = '0;
    end else if (acc_i && keep) begin
      if (last_col) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
      if (produce) begin
        if (fend) begin
          col_d = '0;
          row_d = '0;
          ox_d  = '0;
          oy_d  = '0;
        end else if (ox_last) begin
          ox_d = '0;
          oy_d = oy_q + OYW'(1);
        end else begin
          ox_d = ox_q + AW'(1);
        end
      end
    end
  end

  // position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      ox_q  <= ox_d;
      oy_q  <= oy_d;
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_col_in_row, (WW'(col_q) < eff_w), "input column beyond frame width")
  `ASSERT_ALWAYS(a_row_bound, (row_q <= (RW'(eff_h) + RW'(1))), "input row beyond drain range")
  `ASSERT_ALWAYS(a_out_pos, ((WW'(ox_q) < eff_w) && (HW'(oy_q) < eff_h)), "output position outside frame")
  `ASSERT_NEXT(a_frame_wrap, (acc_i && keep && produce && fend && !clear_i), ((row_q == '0) && (col_q == '0) && (ox_q == '0) && (oy_q == '0)), "frame end did not restart position")

endmodule

[rtl/core/gblur_linebuf.sv]
// two-row line store with registered read and same-address forwarding
module gblur_linebuf #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  gblur_pkg::line_t          wr_data_i,
  output gblur_pkg::line_t          rd_data_o
);
  import gblur_pkg::*;

  line_t mem [DEPTH];
  line_t rd_q;
  line_t fwd_data_q;
  logic  fwd_q;

  // storage array: write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // read of the entry written in the same cycle takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

[rtl/core/gblur_win.sv]
// 3x3 window registers, kernel arithmetic and result register
module gblur_win (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  gblur_pkg::tag_t  tag_i,
  input  gblur_pkg::rgb_t  top_i,
  input  gblur_pkg::rgb_t  mid_i,
  input  gblur_pkg::rgb_t  bot_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic             frame_end_o
);
  import gblur_pkg::*;

  // win_q[0..2]: one column back (top, middle, bottom); [3..5]: two back
  rgb_t win_q [6];
  rgb_t res;
  rgb_t res_q;
  logic fend_q;
  logic out_v_q;

  // kernel or border copy
  always_comb begin
    if (tag_i.border) begin
      res = win_q[1];
    end else begin
      res.r = blur_chan(win_q[3].r, win_q[0].r, top_i.r, win_q[4].r, win_q[1].r,
                        mid_i.r, win_q[5].r, win_q[2].r, bot_i.r);
      res.g = blur_chan(win_q[3].g, win_q[0].g, top_i.g, win_q[4].g, win_q[1].g,
                        mid_i.g, win_q[5].g, win_q[2].g, bot_i.g);
      res.b = blur_chan(win_q[3].b, win_q[0].b, top_i.b, win_q[4].b, win_q[1].b,
                        mid_i.b, win_q[5].b, win_q[2].b, bot_i.b);
    end
  end

  // window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv_i) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top_i;
      win_q[1] <= mid_i;
      win_q[2] <= bot_i;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_i && tag_i.produce) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (adv_i && tag_i.produce) begin
      res_q  <= res;
      fend_q <= tag_i.frame_end;
    end
  end

  assign out_valid_o = out_v_q;
  assign red_out_o   = res_q.r;
  assign green_out_o = res_q.g;
  assign blue_out_o  = res_q.b;
  assign frame_end_o = fend_q;

endmodule

[rtl/core/gaussian_blur_3x3_rgb.sv]
// top level of the streaming 3x3 gaussian blur for rgb pixels
//
//  channel | handshake                    | payload
//  --------+------------------------------+----------------------------------------
//  input   | in_valid_i / in_stall_o      | cmd_i, red_in_i, green_in_i, blue_in_i
//  output  | out_valid_o / out_stall_i    | red_out_o, green_out_o, blue_out_o,
//          |                              | frame_end_o
//  config  | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// one request per clock sustained while the output does not stall; each request passes
// through the line store read stage and then the result register, and a pixel's result is
// registered after the request that completes its neighborhood (frame_width + 1 requests after its pixel).
// the single-port-per-direction line store (one read, one write a cycle) sets the rate.
// reset clears counters, window and valids; line store contents are not cleared.
// an output stall backs up through the read stage into in_stall_o in the same cycle.
module gaussian_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gblur_pkg::PADDR_W-1:0]     paddr,
  input  logic [gblur_pkg::PDATA_W-1:0]     pwdata,
  output logic [gblur_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [7:0]                        red_in_i,
  input  logic [7:0]                        green_in_i,
  input  logic [7:0]                        blue_in_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        red_out_o,
  output logic [7:0]                        green_out_o,
  output logic [7:0]                        blue_out_o,
  output logic                              frame_end_o
);
  import gblur_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic            cfg_we;

  logic            acc;
  logic            take;
  tag_t            tag;
  logic [AW-1:0]   addr;
  rgb_t            px_in;
  rgb_t            px;

  logic            s1_v_q;
  tag_t            s1_tag_q;
  rgb_t            s1_px_q;
  logic [AW-1:0]   s1_addr_q;
  logic            s1_adv;
  logic            s1_load;
  line_t           line_rd;
  line_t           line_wr;

  // config registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(FW_RESET);
      frame_height_q <= FH_W'(FH_RESET);
    end else if (cfg_we) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        frame_width_q <= pwdata[FW_W-1:0];
      end else begin
        frame_height_q <= pwdata[FH_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_FRAME_WIDTH) begin
      prdata = PDATA_W'(frame_width_q);
    end else begin
      prdata = PDATA_W'(frame_height_q);
    end
  end

  // read stage handshake
  assign s1_adv     = s1_v_q && (!s1_tag_q.produce || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_v_q && !s1_adv;
  assign acc        = in_valid_i && !in_stall_o;
  assign s1_load    = acc && take;

  assign px_in.r = red_in_i;
  assign px_in.g = green_in_i;
  assign px_in.b = blue_in_i;

  gblur_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_i        (cfg_we),
    .acc_i          (acc),
    .cmd_i          (cmd_i),
    .px_i           (px_in),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .take_o         (take),
    .tag_o          (tag),
    .addr_o         (addr),
    .px_o           (px)
  );

  // read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_load) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_tag_q  <= tag;
      s1_px_q   <= px;
      s1_addr_q <= addr;
    end
  end

  // line store: rows shift down by one at the column being written
  assign line_wr.far_px  = line_rd.near_px;
  assign line_wr.near_px = s1_px_q;

  gblur_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_load),
    .rd_addr_i (addr),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (line_wr),
    .rd_data_o (line_rd)
  );

  gblur_win u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .tag_i       (s1_tag_q),
    .top_i       (line_rd.far_px),
    .mid_i       (line_rd.near_px),
    .bot_i       (s1_px_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

endmodule

[tb/tb_gaussian_blur_3x3_rgb.sv]
// testbench for the streaming 3x3 rgb gaussian blur, with a self-checking pixel predictor
`timescale 1ns / 1ps

module tb_gaussian_blur_3x3_rgb;
  import gblur_pkg::*;

  localparam int unsigned LINE_MAX    = 1024;
  localparam int unsigned ROWS_MAX    = 4096;
  localparam int unsigned RAND_ITEMS  = 320;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned MAX_REPORTS = 10;

  // one predicted output pixel
  typedef struct packed {
    rgb_t px;
    logic last;
  } expected_px_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall_o;
  logic cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic out_valid_o;
  logic out_stall;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic frame_end_o;

  // predictor state
  rgb_t line_near [LINE_MAX];
  rgb_t line_far [LINE_MAX];
  rgb_t win [6];
  int unsigned col_cnt;
  int unsigned row_cnt;
  int unsigned emit_cnt;
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  expected_px_t expected_pixels[$];

  int unsigned err_cnt;
  int unsigned quiet_cycles;
  bit idle_on;
  bit hold_req;
  int unsigned hold_left;

  gaussian_blur_3x3_rgb i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd),
    .red_in_i   (red_in),
    .green_in_i (green_in),
    .blue_in_i  (blue_in),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .frame_end_o(frame_end_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void flag_error(input string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR: %s", what);
  endfunction

  // frame size as the block applies it
  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > ROWS_MAX) return ROWS_MAX;
    return height_reg;
  endfunction

  // weighted neighborhood sum of one channel, truncated by 16
  function automatic logic [7:0] smooth(input logic [8:0][23:0] nb, input int unsigned sh);
    int unsigned acc;
    int unsigned i;
    acc = 0;
    for (i = 0; i < 9; i++) begin
      acc += nb[i][sh +: 8] * ((i == 4) ? 4 : (i % 2 == 1) ? 2 : 1);
    end
    return 8'(acc >> 4);
  endfunction

  function automatic void reset_position();
    col_cnt  = 0;
    row_cnt  = 0;
    emit_cnt = 0;
  endfunction

  // advance the predictor by one accepted request, queueing any output pixel
  function automatic void predict_blur(input logic drain, input rgb_t px_in);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned ox;
    int unsigned oy;
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
    logic [8:0][23:0] nb;
    expected_px_t res;
    bit make;
    w = eff_w();
    h = eff_h();
    // drain only once all pixels are in, pixels only before that
    if (drain != (row_cnt >= h)) return;
    bot  = (drain == CMD_DRAIN) ? '0 : px_in;
    x    = (col_cnt >= w) ? 0 : col_cnt;
    top  = line_far[x];
    mid  = line_near[x];
    make = (row_cnt >= 2) || (row_cnt == 1 && col_cnt >= 1);
    if (make) begin
      ox = emit_cnt % w;
      oy = emit_cnt / w;
      if (ox == 0 || oy == 0 || ox == w - 1 || oy >= h - 1) begin
        res.px = win[1];
      end else begin
        // kernel is point symmetric, so the taps may be packed in either order
        nb = {win[3], win[0], top, win[4], win[1], mid, win[5], win[2], bot};
        res.px.r = smooth(nb, 16);
        res.px.g = smooth(nb, 8);
        res.px.b = smooth(nb, 0);
      end
      res.last = (emit_cnt + 1 == w * h);
      expected_pixels.push_back(res);
    end
    // shift window and line stores
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = bot;
    line_far[x]  = mid;
    line_near[x] = bot;
    col_cnt = x + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (make) begin
      emit_cnt++;
      if (emit_cnt >= w * h) reset_position();
    end
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic rgb_t rand_px();
    rgb_t p;
    p.r = rand_chan();
    p.g = rand_chan();
    p.b = rand_chan();
    return p;
  endfunction

  // output stall: random idling, or a long counted hold on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 10);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    expected_px_t exp_px;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        flag_error($sformatf("unexpected result r=%0d g=%0d b=%0d end=%0b",
                             red_out_o, green_out_o, blue_out_o, frame_end_o));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (red_out_o !== exp_px.px.r || green_out_o !== exp_px.px.g ||
            blue_out_o !== exp_px.px.b || frame_end_o !== exp_px.last) begin
          flag_error($sformatf("expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                               exp_px.px.r, exp_px.px.g, exp_px.px.b, exp_px.last,
                               red_out_o, green_out_o, blue_out_o, frame_end_o));
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // send one request; entered and left at a falling edge
  task automatic send_item(input logic drain, input rgb_t px);
    while (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= drain;
    red_in   <= px.r;
    green_in <= px.g;
    blue_in  <= px.b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_blur(drain, px);
    @(negedge clk_i);
  endtask

  // stop offering, wait for all results, then let in-flight requests settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic read_reg(input logic idx);
    logic [PDATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({idx, 2'b00});
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    want = (idx == REG_FRAME_WIDTH) ? PDATA_W'(width_reg) : PDATA_W'(height_reg);
    if (prdata !== want) begin
      flag_error($sformatf("register %0d read back %0d, expected %0d", idx, prdata, want));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    // bus idle before the next transfer
    @(negedge clk_i);
  endtask

  // register write followed by a read back
  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
    else height_reg = value[FH_W-1:0];
    reset_position();
    @(negedge clk_i);
    read_reg(idx);
  endtask

  // n_pix pixels of a frame; a full frame also gets its drain requests
  task automatic run_frame(input int unsigned n_pix, input int unsigned noise_pct,
                           output int unsigned used);
    int unsigned w;
    int unsigned i;
    w    = eff_w();
    used = n_pix;
    for (i = 0; i < n_pix; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(CMD_DRAIN, rand_px());
      send_item(CMD_PIXEL, rand_px());
    end
    if (n_pix < w * eff_h()) return;
    for (i = 0; i <= w; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(CMD_PIXEL, rand_px());
      send_item(CMD_DRAIN, rand_px());
    end
    used += w + 1;
  endtask

  task automatic test_reset_values();
    read_reg(REG_FRAME_WIDTH);
    read_reg(REG_FRAME_HEIGHT);
  endtask

  // 3x3 frame with saturated channels, a stray drain and a stray pixel
  task automatic test_directed_extremes();
    rgb_t p;
    int unsigned i;
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    send_item(CMD_DRAIN, '1);
    for (i = 0; i < 9; i++) begin
      p.r = 8'hFF;
      p.g = 8'h00;
      p.b = (i % 2 == 1) ? 8'hFF : 8'h00;
      send_item(CMD_PIXEL, p);
    end
    send_item(CMD_DRAIN, '0);
    send_item(CMD_PIXEL, '1);
    for (i = 0; i < 3; i++) send_item(CMD_DRAIN, '1);
    wait_idle();
  endtask

  // zero sizes act as a single pixel frame
  task automatic test_zero_size();
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    send_item(CMD_DRAIN, '0);
    send_item(CMD_PIXEL, rand_px());
    send_item(CMD_PIXEL, rand_px());
    send_item(CMD_DRAIN, rand_px());
    send_item(CMD_DRAIN, rand_px());
    wait_idle();
  endtask

  // oversized registers clamp, and a write in mid frame restarts the frame
  task automatic test_register_extremes();
    int unsigned used;
    write_reg(REG_FRAME_WIDTH, 5);
    write_reg(REG_FRAME_HEIGHT, 6);
    run_frame(13, 0, used);
    wait_idle();
    // partial frames at the clamped sizes, then a full 2x2 frame
    write_reg(REG_FRAME_WIDTH, PDATA_W'({FW_W{1'b1}}));
    write_reg(REG_FRAME_HEIGHT, 1);
    run_frame(40, 2, used);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, PDATA_W'({FH_W{1'b1}}));
    run_frame(40, 0, used);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    run_frame(4, 0, used);
    wait_idle();
  endtask

  // long output hold while the sender keeps offering
  task automatic test_backpressure();
    int unsigned used;
    write_reg(REG_FRAME_WIDTH, 48);
    write_reg(REG_FRAME_HEIGHT, 3);
    hold_req = 1'b1;
    run_frame(eff_w() * eff_h(), 0, used);
    wait_idle();
  endtask

  // random frame sizes and contents, with a few aborted frames
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned used;
    int unsigned w;
    int unsigned h;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: w = $urandom_range(1, 8);
        6, 7, 8:          w = $urandom_range(9, 24);
        default:          w = $urandom_range(25, 64);
      endcase
      h = (w > 24) ? $urandom_range(1, 3) : $urandom_range(1, 7);
      if (w == 1 && $urandom_range(1) == 1) w = 0;
      if (h == 1 && $urandom_range(1) == 1) h = 0;
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      // a stretch in the middle runs without any idling
      idle_on = (sent < 100) || (sent >= 220);
      if ($urandom_range(9) == 0) begin
        run_frame($urandom_range(0, eff_w() * eff_h() - 1), 5, used);
      end else begin
        run_frame(eff_w() * eff_h(), 5, used);
      end
      sent += used;
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    cmd        = CMD_PIXEL;
    red_in     = '0;
    green_in   = '0;
    blue_in    = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    err_cnt    = 0;
    width_reg  = FW_W'(FW_RESET);
    height_reg = FH_W'(FH_RESET);
    reset_position();
    foreach (win[i]) win[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_directed_extremes();
    test_zero_size();
    test_register_extremes();
    test_backpressure();
    test_random_frames();

    wait_idle();
    repeat (SETTLE) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
